@@ rtl/core/sbb_pkg.sv @@
package sbb_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_RADIUS = 16;
  localparam int unsigned RING_ROWS  = 2 * MAX_RADIUS + 2;

  localparam int unsigned DIM_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT);
  localparam int unsigned RAD_W    = 5;
  localparam int unsigned RING_W   = $clog2(RING_ROWS);
  localparam int unsigned TAP_W    = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned RAM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int unsigned RAM_AW   = $clog2(RAM_DEPTH);
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned CFG_W    = 11;

  // Channel sums hold up to 33 * 255; reciprocals are scaled by 2^RECIP_SH.
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned RECIP_W  = 21;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] argb_in;
  } in_t;

  typedef struct packed {
    logic [31:0] argb_out;
    logic        frame_last;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [RING_W-1:0] ymod;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  // ceil(2^20 / (2r+1)); the truncated product is exact for sums below 2^14.
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      5'd0:    m = 21'd1048576;
      5'd1:    m = 21'd349526;
      5'd2:    m = 21'd209716;
      5'd3:    m = 21'd149797;
      5'd4:    m = 21'd116509;
      5'd5:    m = 21'd95326;
      5'd6:    m = 21'd80660;
      5'd7:    m = 21'd69906;
      5'd8:    m = 21'd61681;
      5'd9:    m = 21'd55189;
      5'd10:   m = 21'd49933;
      5'd11:   m = 21'd45591;
      5'd12:   m = 21'd41944;
      5'd13:   m = 21'd38837;
      5'd14:   m = 21'd36158;
      5'd15:   m = 21'd33826;
      default: m = 21'd31776;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/sbb_ram.sv @@
module sbb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/sbb_front.sv @@
module sbb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  sbb_pkg::in_t                item_i,
  input  logic                        cfg_wr_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  output logic [31:0]                 cfg_rdata_o,
  output sbb_pkg::cfg_t               cfg_o,
  output sbb_pkg::ram_wr_t            ram_wr_o,
  output logic                        job_push_o,
  output sbb_pkg::job_t               job_o
);

  localparam int unsigned DW = sbb_pkg::DIM_W;

  logic [sbb_pkg::CFG_W-1:0] width_q, height_q;
  logic [sbb_pkg::RAD_W-1:0] radius_q;

  logic [sbb_pkg::COL_W-1:0]  rx_q, rx_d, ex_q;
  logic [DW-1:0]              ry_q, ry_d;
  logic [sbb_pkg::ROW_W-1:0]  ey_q;
  logic [sbb_pkg::RING_W-1:0] rring_q, rring_d, ering_q;

  logic [DW-1:0] w_eff, h_eff, ty, tx, ey_r, ex_r;
  logic [sbb_pkg::RAD_W-1:0] r_eff;
  logic write_pix, ready_em, last_em, known_idx;

  always_comb begin
    if (width_q == '0) w_eff = DW'(1);
    else if (width_q > DW'(sbb_pkg::MAX_WIDTH)) w_eff = DW'(sbb_pkg::MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == '0) h_eff = DW'(1);
    else if (height_q > DW'(sbb_pkg::MAX_HEIGHT)) h_eff = DW'(sbb_pkg::MAX_HEIGHT);
    else h_eff = height_q;
    r_eff = (radius_q > sbb_pkg::RAD_W'(sbb_pkg::MAX_RADIUS)) ?
            sbb_pkg::RAD_W'(sbb_pkg::MAX_RADIUS) : radius_q;
  end

  assign cfg_o = '{width: w_eff, height: h_eff, radius: r_eff};

  // Store the incoming pixel first, then test whether the next output is ready.
  assign write_pix = accept_i && !item_i.kind && (ry_q < h_eff);

  always_comb begin
    rx_d    = rx_q;
    ry_d    = ry_q;
    rring_d = rring_q;
    if (write_pix) begin
      if (DW'(rx_q) == w_eff - DW'(1)) begin
        rx_d    = '0;
        ry_d    = ry_q + DW'(1);
        rring_d = (rring_q == sbb_pkg::RING_W'(sbb_pkg::RING_ROWS - 1)) ?
                  '0 : rring_q + sbb_pkg::RING_W'(1);
      end else begin
        rx_d = rx_q + sbb_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    ey_r = DW'(ey_q) + DW'(r_eff);
    ex_r = DW'(ex_q) + DW'(r_eff);
    ty   = (ey_r > h_eff - DW'(1)) ? h_eff - DW'(1) : ey_r;
    tx   = (ex_r > w_eff - DW'(1)) ? w_eff - DW'(1) : ex_r;
  end

  assign ready_em = accept_i && ((ry_d > ty) || ((ry_d == ty) && (DW'(rx_d) > tx)));
  assign last_em  = (DW'(ex_q) == w_eff - DW'(1)) && (DW'(ey_q) == h_eff - DW'(1));

  assign ram_wr_o = '{we:   write_pix,
                      addr: sbb_pkg::RAM_AW'(rring_q) * sbb_pkg::RAM_AW'(sbb_pkg::MAX_WIDTH)
                            + sbb_pkg::RAM_AW'(rx_q),
                      data: item_i.argb_in};

  assign job_push_o = ready_em;
  assign job_o      = '{x: ex_q, y: ey_q, ymod: ering_q, last: last_em};

  always_comb begin
    known_idx   = 1'b0;
    cfg_rdata_o = '0;
    unique case (cfg_idx_i)
      sbb_pkg::REG_WIDTH: begin
        known_idx   = 1'b1;
        cfg_rdata_o = 32'(width_q);
      end
      sbb_pkg::REG_HEIGHT: begin
        known_idx   = 1'b1;
        cfg_rdata_o = 32'(height_q);
      end
      sbb_pkg::REG_RADIUS: begin
        known_idx   = 1'b1;
        cfg_rdata_o = 32'(radius_q);
      end
      default: begin
        known_idx   = 1'b0;
        cfg_rdata_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sbb_pkg::CFG_W'(sbb_pkg::MAX_WIDTH);
      height_q <= sbb_pkg::CFG_W'(sbb_pkg::MAX_HEIGHT);
      radius_q <= sbb_pkg::RAD_W'(1);
      rx_q     <= '0;
      ry_q     <= '0;
      rring_q  <= '0;
      ex_q     <= '0;
      ey_q     <= '0;
      ering_q  <= '0;
    end else if (cfg_wr_i && known_idx) begin
      if (cfg_idx_i == sbb_pkg::REG_WIDTH)  width_q  <= cfg_data_i[sbb_pkg::CFG_W-1:0];
      if (cfg_idx_i == sbb_pkg::REG_HEIGHT) height_q <= cfg_data_i[sbb_pkg::CFG_W-1:0];
      if (cfg_idx_i == sbb_pkg::REG_RADIUS) radius_q <= cfg_data_i[sbb_pkg::RAD_W-1:0];
      rx_q    <= '0;
      ry_q    <= '0;
      rring_q <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      ering_q <= '0;
    end else if (accept_i) begin
      if (ready_em && last_em) begin
        rx_q    <= '0;
        ry_q    <= '0;
        rring_q <= '0;
        ex_q    <= '0;
        ey_q    <= '0;
        ering_q <= '0;
      end else begin
        rx_q    <= rx_d;
        ry_q    <= ry_d;
        rring_q <= rring_d;
        if (ready_em) begin
          if (DW'(ex_q) == w_eff - DW'(1)) begin
            ex_q    <= '0;
            ey_q    <= ey_q + sbb_pkg::ROW_W'(1);
            ering_q <= (ering_q == sbb_pkg::RING_W'(sbb_pkg::RING_ROWS - 1)) ?
                       '0 : ering_q + sbb_pkg::RING_W'(1);
          end else begin
            ex_q <= ex_q + sbb_pkg::COL_W'(1);
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/sbb_job_q.sv @@
module sbb_job_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbb_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          empty_o,
  output sbb_pkg::job_t job_o
);

  sbb_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

endmodule

@@ rtl/core/sbb_back.sv @@
module sbb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbb_pkg::cfg_t              cfg_i,
  input  logic                       job_empty_i,
  input  sbb_pkg::job_t              job_i,
  output logic                       job_pop_o,
  output logic                       busy_o,
  output logic                       re_o,
  output logic [sbb_pkg::RAM_AW-1:0] raddr_o,
  input  logic [31:0]                rdata_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output sbb_pkg::out_t              out_o
);

  localparam int unsigned DW = sbb_pkg::DIM_W;
  localparam int unsigned TW = sbb_pkg::TAP_W;
  localparam int unsigned SW = sbb_pkg::SUM_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADDR = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_HDIV = 6'b001000,
    ST_VDIV = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q;
  sbb_pkg::job_t job_q;
  logic [TW-1:0] tt_q, ss_q, last_tap;
  logic [2:0]    cnt_q;
  logic [1:0]    pch_q;
  logic [sbb_pkg::RING_W-1:0] ring_q;
  logic [SW-1:0] hsum_q [4];
  logic [SW-1:0] vsum_q [4];
  logic [7:0]    res_q  [4];
  logic [sbb_pkg::PROD_W-1:0] prod_q;
  logic [SW-1:0] div_in, quot;
  logic signed [DW+1:0] col_s;
  logic [sbb_pkg::COL_W-1:0] col;
  logic [DW+1:0] ynext;

  sbb_pkg::out_t rq_mem_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_full, rq_push, rq_pop;

  assign last_tap = TW'({cfg_i.radius, 1'b0});
  assign busy_o   = (state_q != ST_IDLE);
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;

  // Horizontal tap position, replicated at the left and right edges.
  always_comb begin
    col_s = $signed({2'b00, DW'(job_q.x)}) + $signed((DW+2)'(ss_q))
          - $signed((DW+2)'(cfg_i.radius));
    if (col_s < 0) begin
      col = '0;
    end else if (col_s > $signed({2'b00, cfg_i.width - DW'(1)})) begin
      col = sbb_pkg::COL_W'(cfg_i.width - DW'(1));
    end else begin
      col = col_s[sbb_pkg::COL_W-1:0];
    end
  end

  assign re_o    = (state_q == ST_ADDR);
  assign raddr_o = sbb_pkg::RAM_AW'(ring_q) * sbb_pkg::RAM_AW'(sbb_pkg::MAX_WIDTH)
                 + sbb_pkg::RAM_AW'(col);

  // Unclamped row of the next tap row plus the radius.
  assign ynext = (DW+2)'(job_q.y) + (DW+2)'(tt_q) + (DW+2)'(1);

  assign div_in = (state_q == ST_HDIV) ? hsum_q[cnt_q[1:0]] : vsum_q[cnt_q[1:0]];
  assign quot   = prod_q[sbb_pkg::RECIP_SH +: SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tt_q    <= '0;
      ss_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            tt_q    <= '0;
            ss_q    <= '0;
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR: state_q <= ST_ACC;
        ST_ACC: begin
          if (ss_q == last_tap) begin
            ss_q    <= '0;
            cnt_q   <= '0;
            state_q <= ST_HDIV;
          end else begin
            ss_q    <= ss_q + TW'(1);
            state_q <= ST_ADDR;
          end
        end
        ST_HDIV: begin
          if (cnt_q == 3'd4) begin
            cnt_q <= '0;
            if (tt_q == last_tap) begin
              state_q <= ST_VDIV;
            end else begin
              tt_q    <= tt_q + TW'(1);
              state_q <= ST_ADDR;
            end
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_VDIV: begin
          if (cnt_q == 3'd4) begin
            cnt_q   <= '0;
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_OUT: begin
          if (!rq_full) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_q <= job_i;
          for (int c = 0; c < 4; c++) begin
            hsum_q[c] <= '0;
            vsum_q[c] <= '0;
          end
          // Top tap row: clamped at row 0, else y - R in the ring.
          if (DW'(job_i.y) < DW'(cfg_i.radius)) begin
            ring_q <= '0;
          end else begin
            ring_q <= (job_i.ymod >= sbb_pkg::RING_W'(cfg_i.radius)) ?
                      job_i.ymod - sbb_pkg::RING_W'(cfg_i.radius) :
                      job_i.ymod + sbb_pkg::RING_W'(sbb_pkg::RING_ROWS)
                      - sbb_pkg::RING_W'(cfg_i.radius);
          end
        end
      end
      ST_ACC: begin
        for (int c = 0; c < 4; c++) begin
          hsum_q[c] <= hsum_q[c] + SW'(rdata_i[8*c +: 8]);
        end
      end
      ST_HDIV: begin
        if (cnt_q != 3'd4) begin
          prod_q <= sbb_pkg::PROD_W'(div_in) * sbb_pkg::PROD_W'(sbb_pkg::recip(cfg_i.radius));
          pch_q  <= cnt_q[1:0];
        end
        if (cnt_q != 3'd0) begin
          vsum_q[pch_q] <= vsum_q[pch_q] + quot;
        end
        if (cnt_q == 3'd4) begin
          for (int c = 0; c < 4; c++) begin
            hsum_q[c] <= '0;
          end
          // The source row only moves while the next tap row is inside the frame.
          if ((ynext > (DW+2)'(cfg_i.radius)) &&
              (ynext < (DW+2)'(cfg_i.height) + (DW+2)'(cfg_i.radius))) begin
            ring_q <= (ring_q == sbb_pkg::RING_W'(sbb_pkg::RING_ROWS - 1)) ?
                      '0 : ring_q + sbb_pkg::RING_W'(1);
          end
        end
      end
      ST_VDIV: begin
        if (cnt_q != 3'd4) begin
          prod_q <= sbb_pkg::PROD_W'(div_in) * sbb_pkg::PROD_W'(sbb_pkg::recip(cfg_i.radius));
          pch_q  <= cnt_q[1:0];
        end
        if (cnt_q != 3'd0) begin
          res_q[pch_q] <= quot[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Two-entry result queue toward the consumer.
  assign rq_full = (rq_cnt_q == 2'd2);
  assign empty_o = (rq_cnt_q == 2'd0);
  assign rq_push = (state_q == ST_OUT) && !rq_full;
  assign rq_pop  = pop_i && !empty_o;
  assign out_o   = rq_mem_q[rq_rd_q];

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem_q[rq_wr_q] <= '{argb_out: {res_q[3], res_q[2], res_q[1], res_q[0]},
                             frame_last: job_q.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (rq_push) rq_wr_q <= !rq_wr_q;
      if (rq_pop)  rq_rd_q <= !rq_rd_q;
      if (rq_push && !rq_pop)      rq_cnt_q <= rq_cnt_q + 2'd1;
      else if (rq_pop && !rq_push) rq_cnt_q <= rq_cnt_q - 2'd1;
    end
  end

endmodule

@@ rtl/core/separable_box_blur.sv @@
// One tap-serial unit computes each result, reading the line store once per tap.
// The item that completes a result becomes a job; no item is taken again until
// the back end has read and divided every tap and queued that result.
// Other items go back to back; a result that finds two unpopped ones holds the input.
// Reset is asynchronous and active low: registers return to 1024 x 1024, radius 1,
// both queues empty and the frame counters at zero. The line store is not cleared.
module separable_box_blur (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  sbb_pkg::in_t                 in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output sbb_pkg::out_t                out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  sbb_pkg::cfg_t    cfg;
  sbb_pkg::ram_wr_t ram_wr;
  sbb_pkg::job_t    job_in, job_out;
  logic job_push, job_pop, job_empty, back_busy, accept, re;
  logic [sbb_pkg::RAM_AW-1:0] raddr;
  logic [31:0] rdata;

  assign pready = 1'b1;
  // New pixels would overwrite ring rows still in use, so input waits on the back.
  assign full   = !job_empty || back_busy;
  assign accept = push && !full;

  sbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_wr_i    (psel && penable && pwrite),
    .cfg_idx_i   (paddr[3:2]),
    .cfg_data_i  (pwdata),
    .cfg_rdata_o (prdata),
    .cfg_o       (cfg),
    .ram_wr_o    (ram_wr),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  sbb_job_q u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_out)
  );

  sbb_ram #(
    .WIDTH (32),
    .DEPTH (sbb_pkg::RAM_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_data_o)
  );

endmodule

@@ rtl/core/sbb_checker.sv @@
module sbb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input logic          pready,
  input sbb_pkg::out_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_data_o))
    else $error("waiting result changed");

  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> empty && !full)
    else $error("queues not empty after reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port stalled");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .pready     (pready),
  .out_data_o (out_data_o)
);
